FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Implication: antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/csa_pkg.sv
// Package of the contiguous segment allocator: item types and codes.
`default_nettype none
package csa_pkg;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF     = 16;
    localparam logic [15:0] MEM_SIZE_RESET = 16'hFFFF;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_NEXT  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic REG_FIT_POLICY  = 1'b0;
    localparam logic REG_MEMORY_SIZE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] alloc_len;
        logic [7:0]  owner_id;
        logic [15:0] scan_origin;
        logic [15:0] block_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0] seg_start;
        logic [15:0] seg_end;
        logic [15:0] seg_size;
        logic [7:0]  seg_owner;
        logic [1:0]  status;
    } t_out_item;
endpackage
`default_nettype wire

FILE: rtl/contiguous_segment_allocator_unit.sv
// Top level of the contiguous segment allocator: table, sequencer and result register.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_in_valid/o_in_ready   | t_in_item
//  out     | output    | o_out_valid/i_out_ready | t_out_item
//  cfg     | input     | i_cfg_we (no wait)      | i_cfg_index, i_cfg_wdata
//
// One item at a time. The sequencer reads one table entry per cycle through a
// single read port: a scan of up to N entries (next fit adds a locate scan of
// up to N), then the insert or merge shifts move entries one by one (N = entries).
// Synchronous active-low reset gives one free segment of 65535 and policy 0.
// A result waits in the output register while the output side stalls.
`default_nettype none
`include "assert_macros.svh"
module contiguous_segment_allocator_unit #(
    parameter int TABLE_ENTRIES = csa_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = csa_pkg::ADDR_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  csa_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output csa_pkg::t_out_item  o_out_item,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire  [15:0]         i_cfg_wdata
);
    import csa_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef struct packed {
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
        logic [ADDR_BITS-1:0] size;
        logic [7:0]           owner;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_LOCATE, S_SCAN, S_DECIDE, S_SHIFT_UP, S_WR_GOT,
        S_FIND, S_PREV, S_NEXT, S_SHIFT_DN, S_DONE
    } t_state;

    t_entry    r_tab [TABLE_ENTRIES];
    t_state    r_state;
    logic [CW-1:0] r_count, r_j, r_k, r_idx, r_pick;
    logic [1:0]    r_policy;
    t_in_item      r_in;
    t_entry        r_cur;
    logic          r_found, r_after_prev;
    t_out_item     r_res;

    logic [CW-1:0] rd_addr;
    t_entry        rd;
    logic [EW-1:0] req_e;
    logic [ADDR_BITS-1:0] req_a;
    logic [ADDR_BITS-1:0] init_sz;
    logic          fit, better;
    logic [CW-1:0] j_next;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        got, rem, merged_prev, merged_next;
    logic [EW-1:0] sz_e;

    // Single read port, address chosen by state
    always_comb begin
        unique case (r_state)
            S_PREV:     rd_addr = r_idx - CW'(1);
            S_NEXT:     rd_addr = r_idx + CW'(1);
            S_SHIFT_UP: rd_addr = r_j - CW'(1);
            S_SHIFT_DN: rd_addr = r_j + CW'(1);
            default:    rd_addr = r_j;
        endcase
    end
    assign rd = r_tab[rd_addr[IW-1:0]];

    // Request in table width; config size masked to table width
    assign req_e   = EW'(r_in.alloc_len);
    assign req_a   = req_e[ADDR_BITS-1:0];
    assign sz_e    = EW'(i_cfg_wdata);
    assign init_sz = sz_e[ADDR_BITS-1:0];

    assign fit = (rd.owner == 8'd0) && (EW'(rd.size) >= req_e);
    assign better = !r_found ||
                    ((r_policy == POL_BEST)  && (rd.size < r_cur.size)) ||
                    ((r_policy == POL_WORST) && (rd.size > r_cur.size));
    assign j_next = (r_j + CW'(1) == r_count) ? '0 : r_j + CW'(1);

    // Allocated part and free remainder of the chosen segment
    assign got = '{lo: r_cur.lo, hi: r_cur.lo + req_a - ADDR_BITS'(1),
                   size: req_a, owner: r_in.owner_id};
    assign rem = '{lo: r_cur.lo + req_a, hi: r_cur.hi,
                   size: r_cur.size - req_a, owner: 8'd0};
    assign merged_prev = '{lo: rd.lo, hi: r_cur.hi,
                           size: rd.size + r_cur.size, owner: 8'd0};
    assign merged_next = '{lo: r_cur.lo, hi: rd.hi,
                           size: r_cur.size + rd.size, owner: 8'd0};

    // Single table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_j;
        wr_data = rd;
        unique case (r_state)
            S_FIND: begin
                wr_en   = (r_j != r_count) && (EW'(rd.lo) == EW'(r_in.block_start));
                wr_addr = r_j;
                wr_data = '{lo: rd.lo, hi: rd.hi, size: rd.size, owner: 8'd0};
            end
            S_PREV: begin
                wr_en   = (r_idx != '0) && (rd.owner == 8'd0);
                wr_addr = r_idx - CW'(1);
                wr_data = merged_prev;
            end
            S_NEXT: begin
                wr_en   = (r_idx + CW'(1) < r_count) && (rd.owner == 8'd0);
                wr_addr = r_idx;
                wr_data = merged_next;
            end
            S_SHIFT_DN: begin
                wr_en   = (r_j + CW'(1) < r_count);
                wr_addr = r_j;
                wr_data = rd;
            end
            S_SHIFT_UP: begin
                wr_en   = 1'b1;
                if (r_j > r_pick) begin
                    wr_addr = r_j;
                    wr_data = rd;
                end else begin
                    wr_addr = r_pick + CW'(1);
                    wr_data = rem;
                end
            end
            S_WR_GOT: begin
                wr_en   = 1'b1;
                wr_addr = r_pick;
                wr_data = got;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Table storage; a memory_size write re-initializes entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab[0] <= '{lo: '0, hi: ADDR_BITS'(MEM_SIZE_RESET) - ADDR_BITS'(1),
                          size: ADDR_BITS'(MEM_SIZE_RESET), owner: 8'd0};
        end else if (i_cfg_we && i_cfg_index == REG_MEMORY_SIZE) begin
            r_tab[0] <= '{lo: '0, hi: init_sz - ADDR_BITS'(1), size: init_sz, owner: 8'd0};
        end else if (wr_en) begin
            r_tab[wr_addr[IW-1:0]] <= wr_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= CW'(1);
            r_policy <= POL_FIRST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FIT_POLICY) begin
                    r_policy <= i_cfg_wdata[1:0];
                end else begin
                    r_count <= (init_sz == '0) ? '0 : CW'(1);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_item;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_found <= 1'b0;
                        r_res   <= '0;
                        if (i_in_item.command == CMD_RELEASE) begin
                            r_state <= S_FIND;
                        end else if (i_in_item.alloc_len == '0 ||
                                     i_in_item.owner_id == '0 || r_count == '0) begin
                            r_res.status <= ST_NO_FIT;
                            r_state      <= S_DONE;
                        end else if (r_policy == POL_NEXT) begin
                            r_state <= S_LOCATE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_LOCATE: begin
                    if (r_j == r_count) begin
                        r_j     <= '0;
                        r_state <= S_SCAN;
                    end else if (EW'(rd.lo) <= EW'(r_in.scan_origin) &&
                                 EW'(rd.hi) >= EW'(r_in.scan_origin)) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_SCAN: begin
                    if (r_k == r_count) begin
                        r_state <= S_DECIDE;
                    end else begin
                        if (fit && better) begin
                            r_found <= 1'b1;
                            r_pick  <= r_j;
                            r_cur   <= rd;
                        end
                        if (fit && (r_policy == POL_FIRST || r_policy == POL_NEXT)) begin
                            r_state <= S_DECIDE;
                        end
                        r_k <= r_k + CW'(1);
                        r_j <= j_next;
                    end
                end
                S_DECIDE: begin
                    if (!r_found) begin
                        r_res.status <= ST_NO_FIT;
                        r_state      <= S_DONE;
                    end else if (r_cur.size != req_a) begin
                        if (r_count >= FULL_COUNT) begin
                            r_res.status <= ST_FULL;
                            r_state      <= S_DONE;
                        end else begin
                            r_j     <= r_count;
                            r_state <= S_SHIFT_UP;
                        end
                    end else begin
                        r_state <= S_WR_GOT;
                    end
                end
                S_SHIFT_UP: begin
                    if (r_j > r_pick) begin
                        r_j <= r_j - CW'(1);
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_WR_GOT;
                    end
                end
                S_WR_GOT: begin
                    r_res.seg_start <= 16'(EW'(got.lo));
                    r_res.seg_end   <= 16'(EW'(got.hi));
                    r_res.seg_size  <= 16'(EW'(got.size));
                    r_res.seg_owner <= got.owner;
                    r_res.status    <= ST_OK;
                    r_state         <= S_DONE;
                end
                S_FIND: begin
                    if (r_j == r_count) begin
                        r_res.status <= ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end else if (EW'(rd.lo) == EW'(r_in.block_start)) begin
                        r_idx   <= r_j;
                        r_cur   <= '{lo: rd.lo, hi: rd.hi, size: rd.size, owner: 8'd0};
                        r_state <= S_PREV;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_PREV: begin
                    if (r_idx != '0 && rd.owner == 8'd0) begin
                        r_cur        <= merged_prev;
                        r_j          <= r_idx;
                        r_idx        <= r_idx - CW'(1);
                        r_after_prev <= 1'b1;
                        r_state      <= S_SHIFT_DN;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_idx + CW'(1) < r_count && rd.owner == 8'd0) begin
                        r_cur        <= merged_next;
                        r_j          <= r_idx + CW'(1);
                        r_after_prev <= 1'b0;
                        r_state      <= S_SHIFT_DN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT_DN: begin
                    if (r_j + CW'(1) < r_count) begin
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= r_after_prev ? S_NEXT : S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_item  = r_res;

    // Checks
    `ASSERT_CLKD(a_one_item, i_clk, i_rst_n, !(o_in_ready && o_out_valid))
    `ASSERT_CLKD(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_NEXT(a_ready_after_result, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready)
endmodule
`default_nettype wire
